>>> rtl/pgdecor_pkg.sv
// Shared types, constants and pixel functions for the palette pixel reconstructor.
package pgdecor_pkg;

  // Palette geometry.
  localparam int PAL_DEPTH = 256;
  localparam int PAL_AW    = $clog2(PAL_DEPTH);
  localparam int PIX_W     = 16;

  // Item kinds carried on the input tuser.
  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_PAL   = 2'd1,
    FUNC_DATA  = 2'd2
  } func_t;

  // Chunk tiers; TIER_NONE means no chunk is active.
  typedef enum logic [1:0] {
    TIER_NONE = 2'd0,
    TIER_NIB  = 2'd1,
    TIER_BYTE = 2'd2,
    TIER_GDEC = 2'd3
  } tier_t;

  // Palette write request.
  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
    logic [PIX_W-1:0]  data;
  } pal_wr_t;

  // Palette read request, two addresses per cycle.
  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr_a;
    logic [PAL_AW-1:0] addr_b;
  } pal_rd_t;

  // Registered palette read response; hit is low for never-written entries.
  typedef struct packed {
    logic             hit_a;
    logic             hit_b;
    logic [PIX_W-1:0] data_a;
    logic [PIX_W-1:0] data_b;
  } pal_rsp_t;

  // Undo green decorrelation: red and blue each get half of green, modulo 32.
  function automatic logic [PIX_W-1:0] gdecor_inv(input logic [PIX_W-1:0] v);
    logic [4:0] dr;
    logic [5:0] g;
    logic [4:0] db;
    logic [4:0] r;
    logic [4:0] b;
    dr = v[15:11];
    g  = v[10:5];
    db = v[4:0];
    r  = dr + g[5:1];
    b  = db + g[5:1];
    return {r, g, b};
  endfunction

  // Optional swap of the two pixel bytes.
  function automatic logic [PIX_W-1:0] swap_pix(input logic [PIX_W-1:0] v,
                                                input logic sw);
    return sw ? {v[7:0], v[15:8]} : v;
  endfunction

endpackage

>>> rtl/pgdecor_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pgdecor_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/pgdecor_palette.sv
// Palette store: two RAM copies for two lookups per cycle, plus per-entry valid bits.
module pgdecor_palette (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pgdecor_pkg::pal_wr_t  wr,
  input  pgdecor_pkg::pal_rd_t  rd,
  output pgdecor_pkg::pal_rsp_t rsp
);

  logic [pgdecor_pkg::PAL_DEPTH-1:0] vld_r;
  logic                              hit_a_r;
  logic                              hit_b_r;
  logic [pgdecor_pkg::PIX_W-1:0]     data_a;
  logic [pgdecor_pkg::PIX_W-1:0]     data_b;

  // Valid bits flag unwritten entries (hit low) without a clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  // Valid bits are sampled alongside the RAM read.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      hit_a_r <= vld_r[rd.addr_a];
      hit_b_r <= vld_r[rd.addr_b];
    end
  end

  // Both copies take every write so they always hold the same colors.
  pgdecor_ram #(
    .WIDTH (pgdecor_pkg::PIX_W),
    .DEPTH (pgdecor_pkg::PAL_DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd.en),
    .raddr (rd.addr_a),
    .rdata (data_a)
  );

  pgdecor_ram #(
    .WIDTH (pgdecor_pkg::PIX_W),
    .DEPTH (pgdecor_pkg::PAL_DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd.en),
    .raddr (rd.addr_b),
    .rdata (data_b)
  );

  assign rsp.hit_a  = hit_a_r;
  assign rsp.hit_b  = hit_b_r;
  assign rsp.data_a = data_a;
  assign rsp.data_b = data_b;

endmodule

>>> rtl/palette_gdecor_pixel_reconstructor.sv
// Top level: RGB565 pixel rebuild from palette, nibble and green-decorrelated chunks.
//
//   Channel   Direction  Word contents
//   in_*      slave      tuser: func; tdata: tier, pal_index, pal_color, data_word
//   out_*     master     tdata: pixel; tlast: last pixel of the input word
//   cfg_*     write      cfg_wr_data: swap_bytes
//
// One input word per cycle while in_tready is high; a tier 1 data word gives two
// output pixels. A data word's first pixel is registered by the palette RAM read and
// the lookup stage at the accepting edge, then by the output register. Reset clears
// the tier, the swap flag and the palette valid bits; no clearing pass is needed. A
// stalled output holds its pixel and the lookup stage behind it, and in_tready falls
// until room frees up.
module palette_gdecor_pixel_reconstructor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] func
  input  logic [47:0] in_tdata,   // [1:0] tier, [9:2] pal_index, [25:10] pal_color,
                                  // [41:26] data_word, [47:42] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] pixel
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data // swap_bytes
);

  localparam int AW = pgdecor_pkg::PAL_AW;

  pgdecor_pkg::func_t    func;
  pgdecor_pkg::tier_t    in_tier;
  logic [7:0]            pal_index;
  logic [15:0]           pal_color;
  logic [15:0]           data_word;
  logic                  accept;
  logic                  take;
  logic                  pal_ok;
  logic                  ok_a;
  logic                  ok_b;

  pgdecor_pkg::pal_wr_t  wr;
  pgdecor_pkg::pal_rd_t  rd;
  pgdecor_pkg::pal_rsp_t rsp;

  logic                  swap_r;
  pgdecor_pkg::tier_t    active_tier_r;
  pgdecor_pkg::tier_t    active_tier_nxt;

  logic                  s1_v_r;
  pgdecor_pkg::tier_t    s1_tier_r;
  logic [15:0]           s1_word_r;
  logic                  s1_ok_a_r;
  logic                  s1_ok_b_r;
  logic                  s1_phase_r;
  logic                  s1_last;
  logic                  s1_go;
  logic                  emit;
  logic                  ofree;
  logic [15:0]           pix;

  logic                  out_v_r;
  logic [15:0]           out_pix_r;
  logic                  out_last_r;

  // Unpack the input word.
  assign func      = pgdecor_pkg::func_t'(in_tuser);
  assign in_tier   = pgdecor_pkg::tier_t'(in_tdata[1:0]);
  assign pal_index = in_tdata[9:2];
  assign pal_color = in_tdata[25:10];
  assign data_word = in_tdata[41:26];
  assign accept    = in_tvalid && in_tready;

  // Range checks against the palette depth.
  assign pal_ok = {1'b0, pal_index} < 9'(pgdecor_pkg::PAL_DEPTH);
  assign ok_a   = (active_tier_r == pgdecor_pkg::TIER_NIB)
                ? ({5'b0, data_word[7:4]} < 9'(pgdecor_pkg::PAL_DEPTH))
                : ({1'b0, data_word[7:0]} < 9'(pgdecor_pkg::PAL_DEPTH));
  assign ok_b   = {5'b0, data_word[3:0]} < 9'(pgdecor_pkg::PAL_DEPTH);

  // Decode the accepted word into tier updates, palette writes and lookups.
  always_comb begin
    active_tier_nxt = active_tier_r;
    take            = 1'b0;
    wr              = '0;
    rd              = '0;
    wr.addr         = pal_index[AW-1:0];
    wr.data         = pal_color;
    rd.addr_a       = (active_tier_r == pgdecor_pkg::TIER_NIB)
                    ? AW'(data_word[7:4]) : data_word[AW-1:0];
    rd.addr_b       = AW'(data_word[3:0]);
    if (accept) begin
      case (func)
        pgdecor_pkg::FUNC_START: begin
          active_tier_nxt = in_tier;
        end
        pgdecor_pkg::FUNC_PAL: begin
          wr.en = pal_ok;
        end
        pgdecor_pkg::FUNC_DATA: begin
          take  = (active_tier_r != pgdecor_pkg::TIER_NONE);
          rd.en = (active_tier_r == pgdecor_pkg::TIER_NIB) ||
                  (active_tier_r == pgdecor_pkg::TIER_BYTE);
        end
        default: begin
        end
      endcase
    end
  end

  // Configuration and chunk tier registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r        <= 1'b0;
      active_tier_r <= pgdecor_pkg::TIER_NONE;
    end else begin
      if (cfg_wr_en) begin
        swap_r <= cfg_wr_data;
      end
      active_tier_r <= active_tier_nxt;
    end
  end

  pgdecor_palette u_palette (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .rd    (rd),
    .rsp   (rsp)
  );

  // Lookup stage handshake: a tier 1 word stays for two output pixels.
  assign ofree     = !out_v_r || out_tready;
  assign s1_last   = (s1_tier_r != pgdecor_pkg::TIER_NIB) || s1_phase_r;
  assign emit      = s1_v_r && ofree;
  assign s1_go     = emit && s1_last;
  assign in_tready = !s1_v_r || s1_go;

  // Lookup stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s1_phase_r <= 1'b0;
    end else if (!s1_v_r || s1_go) begin
      s1_v_r     <= take;
      s1_phase_r <= 1'b0;
    end else if (emit) begin
      s1_phase_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_tier_r <= active_tier_r;
      s1_word_r <= data_word;
      s1_ok_a_r <= ok_a;
      s1_ok_b_r <= ok_b;
    end
  end

  // Pixel selection: palette colors read as zero when unwritten or out of range.
  always_comb begin
    case (s1_tier_r)
      pgdecor_pkg::TIER_NIB: begin
        if (s1_phase_r) begin
          pix = (s1_ok_b_r && rsp.hit_b) ? rsp.data_b : '0;
        end else begin
          pix = (s1_ok_a_r && rsp.hit_a) ? rsp.data_a : '0;
        end
      end
      pgdecor_pkg::TIER_BYTE: begin
        pix = (s1_ok_a_r && rsp.hit_a) ? rsp.data_a : '0;
      end
      pgdecor_pkg::TIER_GDEC: begin
        pix = pgdecor_pkg::gdecor_inv(s1_word_r);
      end
      default: begin
        pix = '0;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (emit) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pix_r  <= pgdecor_pkg::swap_pix(pix, swap_r);
      out_last_r <= s1_last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;

endmodule

>>> rtl/pgdecor_checker.sv
// Port-level checker for the pixel reconstructor, bound to the top level.
module pgdecor_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // Reset empties the output register.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // The second pixel of a nibble pair follows right after the first is taken.
  a_pair_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("second pixel of a pair did not follow");

  // While the first pixel of a pair is stalled, no new input word is taken.
  a_pair_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast && !out_tready |-> !in_tready)
    else $error("input accepted while a pixel pair is stalled");

endmodule

bind palette_gdecor_pixel_reconstructor pgdecor_checker u_pgdecor_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
